// ----- hw/rtl/bpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// shared constants and types for the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int MAX_PAGES_DEF  = 4096;
    localparam int WORD_BITS_DEF  = 64;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam int ADDR_W  = 48;
    localparam int COUNT_W = 13;
    localparam int STAT_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_ZERO      = 3'd2,
        ST_OUTSIDE   = 3'd3,
        ST_MISALIGN  = 3'd4,
        ST_RESERVED  = 3'd5,
        ST_NOT_ALLOC = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE  = 2'd0,
        REG_TOTAL = 2'd1,
        REG_RESV  = 2'd2
    } cfg_idx_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

// ----- hw/rtl/bpa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- hw/rtl/bitmap_page_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// first fit page allocator over a one bit per page use map held in ram
// ----------------------------------------------------------------------------
// channel   dir  beat contents
// s_axis    in   tuser: operation; tdata: page_count[12:0], address[60:13]
// m_axis    out  tdata: status, granted_address, freed, rejected, pages_in_use
// cfg       in   cfg_index selects region_base, page_total, reserved_count
//
// after reset a clearing pass writes every map word, one a cycle, while
// s_tready stays low.
// allocate tests one page a cycle from reserved_count until the run is found
// or page_total is passed, then marks the run, reading each map word in S_FRD
// and writing it back in S_MARK, before the result is handed over in S_DONE.
// free takes each page that passes the address checks through S_FCHK, S_FRD
// and S_FWR, a rejected one through S_FCHK alone; a zero count goes to S_DONE.
// one item is in work at a time; the result waits in an output register and
// the next beat is taken once the result has moved there.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
    parameter int MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF,
    parameter int WORD_BITS  = bpa_pkg::WORD_BITS_DEF,
    parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [63:0]                        s_tdata,  // page_count, address
    input  logic                               s_tuser,  // operation
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [95:0]                        m_tdata,  // status, granted, freed, rejected, used
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bpa_pkg::*;

    localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BI_W = $clog2(WORD_BITS);
    localparam int PFN_W = $clog2(MAX_PAGES + 1) + 1;
    localparam int EXT_W = ADDR_W + COUNT_W + PAGE_SHIFT + 2;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_MARK  = 8'b0000_1000,
        S_FCHK  = 8'b0001_0000,
        S_FRD   = 8'b0010_0000,
        S_FWR   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]  base_reg;
    logic [COUNT_W-1:0] total_cfg_reg, resv_cfg_reg;
    logic [COUNT_W-1:0] alloc_reg, alloc_next;

    logic [PFN_W-1:0] eff_total, eff_resv;
    always_comb begin
        eff_total = ({1'b0, total_cfg_reg} > PFN_W'(MAX_PAGES)) ? PFN_W'(MAX_PAGES)
                  : PFN_W'(total_cfg_reg);
        eff_resv = (PFN_W'(resv_cfg_reg) > eff_total) ? eff_total : PFN_W'(resv_cfg_reg);
    end

    // item registers
    logic               op_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [EXT_W-1:0]   addr_reg;        // current page address, no wrap
    logic [PFN_W-1:0]   pfn_reg;
    logic [COUNT_W-1:0] run_len_reg, idx_reg;
    logic [PFN_W-1:0]   seg_first_reg;
    logic [COUNT_W-1:0] freed_reg, rej_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [ADDR_W-1:0]  grant_reg;
    logic [WA_W-1:0]    clr_reg;

    // ram
    logic                 ram_we;
    logic [WA_W-1:0]      ram_addr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // word read ahead during scan: rdata holds word of pfn_reg
    logic [BI_W-1:0] bit_sel;
    logic [WA_W-1:0] word_sel;
    logic            cur_used, in_map;
    assign bit_sel  = BI_W'(pfn_reg % WORD_BITS);
    assign word_sel = WA_W'(pfn_reg / WORD_BITS);
    assign in_map   = pfn_reg < PFN_W'(MAX_PAGES);
    assign cur_used = !in_map || ram_rdata[bit_sel];

    // free address check
    logic [EXT_W-1:0] end_addr, rel;
    logic [STAT_W-1:0] chk_code;
    logic [PFN_W-1:0] rel_pfn;
    assign end_addr = EXT_W'(base_reg) + (EXT_W'(eff_total) << PAGE_SHIFT);
    assign rel      = addr_reg - EXT_W'(base_reg);
    assign rel_pfn  = PFN_W'(rel >> PAGE_SHIFT);
    always_comb begin
        if (addr_reg < EXT_W'(base_reg) || addr_reg >= end_addr) begin
            chk_code = ST_OUTSIDE;
        end else if (addr_reg[PAGE_SHIFT-1:0] != '0) begin
            chk_code = ST_MISALIGN;
        end else if (rel_pfn < eff_resv) begin
            chk_code = ST_RESERVED;
        end else begin
            chk_code = ST_OK;
        end
    end

    logic [PFN_W-1:0] next_pfn;
    assign next_pfn = pfn_reg + PFN_W'(1);

    logic [PFN_W-1:0] found_pfn;
    assign found_pfn = (run_len_reg == '0) ? pfn_reg : seg_first_reg;

    logic mark_last;
    assign mark_last = (idx_reg + COUNT_W'(1)) == cnt_reg;

    logic in_acc, out_acc;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;

    logic [COUNT_W:0] alloc_sum;
    assign alloc_sum = {1'b0, alloc_reg} + {1'b0, cnt_reg};

    always_comb begin
        state_next = state_reg;
        alloc_next = alloc_reg;
        ram_we     = 1'b0;
        ram_addr   = word_sel;
        ram_wdata  = ram_rdata;
        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                if (clr_reg == WA_W'(MAP_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_addr = WA_W'(eff_resv / WORD_BITS);
                if (in_acc) begin
                    if (s_tuser == OP_FREE) begin
                        state_next = (s_tdata[COUNT_W-1:0] == '0) ? S_DONE : S_FCHK;
                    end else begin
                        state_next = (s_tdata[COUNT_W-1:0] == '0) ? S_DONE : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // address next word ahead when crossing a boundary
                ram_addr = WA_W'(next_pfn / WORD_BITS);
                if (pfn_reg >= eff_total) begin
                    state_next = S_DONE;
                end else if (!cur_used && (run_len_reg + COUNT_W'(1)) == cnt_reg) begin
                    state_next = S_FRD;
                end else if (bit_sel != BI_W'(WORD_BITS - 1)) begin
                    ram_addr = word_sel;
                end
            end
            S_MARK: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | (WORD_BITS'(1) << bit_sel);
                if (mark_last) begin
                    state_next = S_DONE;
                    alloc_next = alloc_sum[COUNT_W] ? COUNT_MAX : alloc_sum[COUNT_W-1:0];
                end else begin
                    state_next = S_FRD;
                end
            end
            S_FCHK: begin
                if (idx_reg == cnt_reg) begin
                    state_next = S_DONE;
                end else if (chk_code == ST_OK) begin
                    state_next = S_FRD;
                end
            end
            S_FRD: begin
                state_next = (op_reg == OP_FREE) ? S_FWR : S_MARK;
            end
            S_FWR: begin
                if (in_map && ram_rdata[bit_sel]) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata & ~(WORD_BITS'(1) << bit_sel);
                    if (alloc_reg != '0) begin
                        alloc_next = alloc_reg - COUNT_W'(1);
                    end
                end
                state_next = S_FCHK;
            end
            S_DONE: begin
                if (!m_tvalid || out_acc) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic [PFN_W:0] used_sum;
    assign used_sum = {1'b0, eff_resv} + (PFN_W+1)'(alloc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            alloc_reg     <= '0;
            base_reg      <= '0;
            total_cfg_reg <= COUNT_W'(4096);
            resv_cfg_reg  <= '0;
            m_tvalid      <= 1'b0;
        end else begin
            state_reg <= state_next;
            alloc_reg <= alloc_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + WA_W'(1);
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_BASE:  base_reg      <= cfg_data;
                    REG_TOTAL: total_cfg_reg <= cfg_data[COUNT_W-1:0];
                    REG_RESV:  resv_cfg_reg  <= cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (out_acc) begin
                m_tvalid <= 1'b0;
            end
            if (state_reg == S_DONE && (!m_tvalid || out_acc)) begin
                m_tvalid <= 1'b1;
                m_tdata  <= {6'd0, COUNT_W'(used_sum > (PFN_W+1)'(COUNT_MAX)
                              ? COUNT_MAX : used_sum[COUNT_W-1:0]),
                             rej_reg, freed_reg, grant_reg, status_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                op_reg        <= s_tuser;
                cnt_reg       <= s_tdata[COUNT_W-1:0];
                addr_reg      <= EXT_W'(s_tdata[COUNT_W +: ADDR_W]);
                pfn_reg       <= eff_resv;
                run_len_reg   <= '0;
                seg_first_reg <= eff_resv;
                idx_reg       <= '0;
                freed_reg     <= '0;
                rej_reg       <= '0;
                grant_reg     <= '0;
                status_reg    <= (s_tuser == OP_ALLOC && s_tdata[COUNT_W-1:0] == '0)
                                 ? ST_ZERO : ST_OK;
            end
            S_SCAN: begin
                if (pfn_reg >= eff_total) begin
                    status_reg <= ST_NO_SPACE;
                end else if (cur_used) begin
                    run_len_reg <= '0;
                    pfn_reg     <= next_pfn;
                end else if ((run_len_reg + COUNT_W'(1)) == cnt_reg) begin
                    pfn_reg       <= found_pfn;
                    seg_first_reg <= found_pfn;
                    grant_reg     <= base_reg + (ADDR_W'(found_pfn) << PAGE_SHIFT);
                end else begin
                    if (run_len_reg == '0) begin
                        seg_first_reg <= pfn_reg;
                    end
                    run_len_reg <= run_len_reg + COUNT_W'(1);
                    pfn_reg     <= next_pfn;
                end
            end
            S_MARK: begin
                idx_reg <= idx_reg + COUNT_W'(1);
                if (!mark_last) begin
                    pfn_reg <= next_pfn;
                end
            end
            S_FCHK: begin
                if (idx_reg != cnt_reg) begin
                    pfn_reg <= rel_pfn;
                    if (chk_code != ST_OK) begin
                        if (rej_reg == '0) begin
                            status_reg <= chk_code;
                        end
                        rej_reg  <= rej_reg + COUNT_W'(1);
                        idx_reg  <= idx_reg + COUNT_W'(1);
                        addr_reg <= addr_reg + (EXT_W'(1) << PAGE_SHIFT);
                    end
                end
            end
            S_FWR: begin
                idx_reg  <= idx_reg + COUNT_W'(1);
                addr_reg <= addr_reg + (EXT_W'(1) << PAGE_SHIFT);
                if (in_map && ram_rdata[bit_sel]) begin
                    freed_reg <= freed_reg + COUNT_W'(1);
                end else begin
                    if (rej_reg == '0) begin
                        status_reg <= ST_NOT_ALLOC;
                    end
                    rej_reg <= rej_reg + COUNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // mark pass: idx counts marked pages; it ends on the write of the last page

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_no_we_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !ram_we)
        else $error("map write while idle");
    a_freed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE |-> (freed_reg <= cnt_reg) && (rej_reg <= cnt_reg))
        else $error("free counts exceed request");
endmodule

// ----- test/tb_bitmap_page_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator
// self-checking bench for the first fit bitmap page allocator
// ----------------------------------------------------------------------------
// Allocate and free requests are queued by a stimulus process and fed to the
// block by a clocked driver. Each accepted request is run through an
// in-bench copy of the use map and counters to predict its result. A clocked
// monitor compares every returned result field by field, oldest first.
// The run covers a directed set of edge cases, then randomised phases over
// several region settings. Both sides idle at random, the receiver holds off
// once for a long stretch, and the sender pauses once until all results are
// back.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator;
    import bpa_pkg::*;

    typedef struct {
        logic               op;
        logic [COUNT_W-1:0] cnt;
        logic [ADDR_W-1:0]  adr;
    } req_t;

    typedef struct {
        status_t            st;
        logic [ADDR_W-1:0]  granted;
        logic [COUNT_W-1:0] freed;
        logic [COUNT_W-1:0] rejected;
        logic [COUNT_W-1:0] used;
    } resp_t;

    typedef struct {
        logic [ADDR_W-1:0]  adr;
        logic [COUNT_W-1:0] cnt;
    } run_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata = '0;  // page_count, address
    logic                  s_tuser = OP_ALLOC;  // operation
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [95:0]           m_tdata;  // status, granted, freed, rejected, used
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bitmap_page_allocator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // page model
    logic [ADDR_W-1:0]  base_reg;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] resv_reg;
    bit                 page_used [0:MAX_PAGES_DEF-1];
    int                 alloc_total = 0;

    req_t  pending_reqs[$];
    resp_t expected_resps[$];
    run_t  granted_runs[$];

    int    errors = 0;
    int    n_alloc = 0;
    int    n_free = 0;
    int    n_checked = 0;
    int    n_phases;
    bit    quiet;
    bit    long_done;
    int    s_gap;
    int    m_stall;
    int    m_hold;

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic resp_t predict_alloc_free(logic op, logic [COUNT_W-1:0] cnt,
                                                 logic [ADDR_W-1:0] adr);
        resp_t           r;
        int              total;
        int              resv;
        int              seg_first;
        int              run_len;
        bit              found;
        longint unsigned a;
        longint unsigned end_adr;
        longint unsigned pfn;
        int              used;
        run_t            g;
        r.st       = ST_OK;
        r.granted  = '0;
        r.freed    = '0;
        r.rejected = '0;
        total = (total_reg > MAX_PAGES_DEF) ? MAX_PAGES_DEF : int'(total_reg);
        resv  = (resv_reg > total) ? total : int'(resv_reg);
        if (op == OP_ALLOC) begin
            n_alloc++;
            if (cnt == 0) begin
                r.st = ST_ZERO;
            end else begin
                seg_first = 0;
                run_len = 0;
                found = 0;
                for (int p = resv; p < total; p++) begin
                    if (!page_used[p]) begin
                        if (run_len == 0) seg_first = p;
                        run_len++;
                        if (run_len == cnt) begin
                            found = 1;
                            break;
                        end
                    end else begin
                        run_len = 0;
                    end
                end
                if (found) begin
                    for (int i = 0; i < cnt; i++) page_used[seg_first + i] = 1;
                    alloc_total += cnt;
                    if (alloc_total > 8191) alloc_total = 8191;
                    r.granted = ADDR_W'(base_reg + (longint'(seg_first) << PAGE_SHIFT_DEF));
                    g.adr = r.granted;
                    g.cnt = cnt;
                    granted_runs.push_back(g);
                end else begin
                    r.st = ST_NO_SPACE;
                end
            end
        end else begin
            n_free++;
            end_adr = longint'(base_reg) + (longint'(total) << PAGE_SHIFT_DEF);
            for (int i = 0; i < cnt; i++) begin
                status_t code;
                a = longint'(adr) + (longint'(i) << PAGE_SHIFT_DEF);
                code = ST_OK;
                if (a < base_reg || a >= end_adr) begin
                    code = ST_OUTSIDE;
                end else if (a[PAGE_SHIFT_DEF-1:0] != 0) begin
                    code = ST_MISALIGN;
                end else begin
                    pfn = (a - base_reg) >> PAGE_SHIFT_DEF;
                    if (pfn < resv) begin
                        code = ST_RESERVED;
                    end else if (pfn >= MAX_PAGES_DEF || !page_used[pfn]) begin
                        code = ST_NOT_ALLOC;
                    end else begin
                        page_used[pfn] = 0;
                        if (alloc_total > 0) alloc_total--;
                        r.freed++;
                    end
                end
                if (code != ST_OK) begin
                    if (r.rejected == 0) r.st = code;
                    r.rejected++;
                end
            end
        end
        used = resv + alloc_total;
        r.used = (used > 8191) ? 13'h1FFF : used[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        errors++;
        $display("mismatch on beat %0d: %s got 0x%0h expected 0x%0h", n_checked, field,
                 got, want);
    endtask

    // driver
    always @(posedge aclk) begin
        req_t  it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap    <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_resps.push_back(predict_alloc_free(s_tuser, s_tdata[12:0],
                                                            s_tdata[60:13]));
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap    <= s_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    it = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= it.op;
                    s_tdata  <= {3'b0, it.adr, it.cnt};
                    if (!quiet && $urandom_range(0, 5) == 0) s_gap <= $urandom_range(1, 8);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            m_stall   <= 0;
            m_hold    <= 0;
            long_done <= 1'b0;
        end else if (m_hold > 0) begin
            m_hold   <= m_hold - 1;
            m_tready <= 1'b0;
        end else if (!long_done && n_checked >= 60) begin
            long_done <= 1'b1;
            m_hold    <= 400;
            m_tready  <= 1'b0;
        end else if (m_stall > 0) begin
            m_stall  <= m_stall - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_stall  <= $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        resp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_resps.size() == 0) begin
                errors++;
                $display("unexpected result beat 0x%0h", m_tdata);
            end else begin
                want = expected_resps.pop_front();
                if (m_tdata[2:0] != want.st)        report_mismatch("status", m_tdata[2:0], want.st);
                if (m_tdata[50:3] != want.granted)  report_mismatch("granted", m_tdata[50:3],
                                                                     want.granted);
                if (m_tdata[63:51] != want.freed)   report_mismatch("freed", m_tdata[63:51],
                                                                     want.freed);
                if (m_tdata[76:64] != want.rejected) report_mismatch("rejected", m_tdata[76:64],
                                                                      want.rejected);
                if (m_tdata[89:77] != want.used)    report_mismatch("in use", m_tdata[89:77],
                                                                     want.used);
            end
            n_checked++;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BASE:  base_reg  = val[ADDR_W-1:0];
            REG_TOTAL: total_reg = val[COUNT_W-1:0];
            REG_RESV:  resv_reg  = val[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_region(logic [ADDR_W-1:0] b, logic [COUNT_W-1:0] t,
                              logic [COUNT_W-1:0] r);
        write_reg(REG_BASE, b);
        write_reg(REG_TOTAL, t);
        write_reg(REG_RESV, r);
        granted_runs.delete();
        n_phases++;
    endtask

    task automatic push_req(logic op, logic [COUNT_W-1:0] c, logic [ADDR_W-1:0] a);
        req_t it;
        it.op  = op;
        it.cnt = c;
        it.adr = a;
        @(negedge aclk);
        pending_reqs.push_back(it);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_resps.size() != 0);
    endtask

    function automatic logic [ADDR_W-1:0] rand48();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    task automatic push_random(int total);
        int   k;
        int   sel;
        run_t g;
        logic [ADDR_W-1:0] a;
        sel = $urandom_range(0, 9);
        if (sel < 4 && granted_runs.size() > 0) begin
            k = $urandom_range(0, granted_runs.size() - 1);
            g = granted_runs[k];
            granted_runs.delete(k);
            if ($urandom_range(0, 3) == 0) g.cnt = COUNT_W'($urandom_range(1, g.cnt));
            push_req(OP_FREE, g.cnt, g.adr);
        end else if (sel < 8) begin
            if ($urandom_range(0, 5) == 0)
                push_req(OP_ALLOC, COUNT_W'($urandom_range(1, total + 2)), rand48());
            else
                push_req(OP_ALLOC, COUNT_W'($urandom_range(1, 12)), rand48());
        end else begin
            case ($urandom_range(0, 2))
                0: a = rand48();
                1: a = base_reg + ADDR_W'($urandom_range(0, total + 4) << PAGE_SHIFT_DEF);
                default: a = base_reg + ADDR_W'($urandom_range(0, (total + 4) << PAGE_SHIFT_DEF));
            endcase
            push_req(1'($urandom_range(0, 1)), ($urandom_range(0, 40) == 0) ?
                     COUNT_W'($urandom_range(0, 8191)) : COUNT_W'($urandom_range(0, 20)), a);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0]  b;
        logic [COUNT_W-1:0] t;
        logic [COUNT_W-1:0] r;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_BASE;
        cfg_data  = '0;
        n_phases = 1;
        quiet = 1'b0;
        base_reg = '0;
        total_reg = 13'd4096;
        resv_reg = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // full region at reset settings
        push_req(OP_ALLOC, 0, '0);
        push_req(OP_ALLOC, 1, '1);
        push_req(OP_ALLOC, 4096, '0);
        push_req(OP_FREE, 1, '0);
        push_req(OP_ALLOC, 4096, '0);
        push_req(OP_ALLOC, 8191, '0);
        push_req(OP_FREE, 4096, '0);
        wait_drained();

        // small offset region with reserved pages
        b = 48'h1234_5678_9000;
        set_region(b, 128, 8);
        push_req(OP_ALLOC, 1, '0);
        push_req(OP_FREE, 1, b);
        push_req(OP_FREE, 2, b + (8 << 12));
        push_req(OP_FREE, 3, b - 4096);
        push_req(OP_FREE, 1, b + (20 << 12) + 1);
        push_req(OP_FREE, 0, b);
        push_req(OP_ALLOC, 121, '0);
        push_req(OP_ALLOC, 120, '0);
        push_req(OP_FREE, 2, b + (127 << 12));
        push_req(OP_FREE, 3, 48'hFFFF_FFFF_F000);
        push_req(OP_FREE, 8191, b + (8 << 12));
        wait_drained();

        // region running past the top of the address space
        set_region(48'hFFFF_FFFF_8000, 16, 0);
        push_req(OP_ALLOC, 16, '0);
        push_req(OP_FREE, 16, 48'hFFFF_FFFF_8000);
        wait_drained();
        set_region('1, 0, 8191);
        push_req(OP_ALLOC, 1, '0);
        push_req(OP_FREE, 1, '1);
        wait_drained();

        for (int ph = 0; ph < 14; ph++) begin
            b = rand48();
            if (ph % 3 != 0) b[11:0] = 12'h000;
            t = COUNT_W'($urandom_range(16, 400));
            r = COUNT_W'($urandom_range(0, t / 4));
            if (ph == 5) t = 4096;
            if (ph == 9) t = 8191;
            if (ph == 7) r = 8191;
            if (ph == 13) quiet = 1'b1;
            set_region(b, t, r);
            for (int i = 0; i < 56; i++) begin
                push_random((t > 4096) ? 4096 : t);
                if (ph == 3 && i == 25) wait_drained();
                if ((t >= 4096) && i == 14) break;
            end
            wait_drained();
        end

        repeat (50) @(posedge aclk);
        if (expected_resps.size() != 0) begin
            $display("%0d results never arrived", expected_resps.size());
        end
        $display("covered %0d allocate and %0d free requests over %0d region settings",
                 n_alloc, n_free, n_phases);
        $display("%0d result beats checked, %0d mismatches", n_checked, errors);
        if (errors == 0 && expected_resps.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("timed out with %0d results outstanding", expected_resps.size());
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- bitmap_page_allocator.f -----
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ram.sv
hw/rtl/bitmap_page_allocator.sv
test/tb_bitmap_page_allocator.sv
